>>> rtl/core/spe_pkg.sv
// shared widths, constants and types of the sinusoidal position code adder
package spe_pkg;

  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned POS_W     = 10;
  localparam int unsigned COL_W     = 9;
  localparam int unsigned PAIR_W    = COL_W - 1;
  localparam int unsigned ROM_DEPTH = 1 << PAIR_W;
  localparam int unsigned ANG_W     = 32;
  localparam int unsigned CODE_W    = 16;
  localparam int unsigned WRAP_SH   = 20;

  localparam longint unsigned LOG2_10000_Q32 = 64'd57070290109;
  localparam longint unsigned LN2_Q32        = 64'd2977044472;
  localparam longint unsigned INV2PI_Q32     = 64'd683565276;

  localparam logic signed [ANG_W-1:0] CORDIC_GAIN_Q30 = 32'sd652032874;

  localparam int unsigned ATAN_ENTRIES = 24;
  localparam logic signed [ANG_W-1:0] ATAN_TURNS [ATAN_ENTRIES] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81
  };

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      odd;
    logic [1:0]                quad;
    logic signed [ANG_W-1:0]   x;
    logic signed [ANG_W-1:0]   y;
    logic signed [ANG_W-1:0]   z;
  } spe_cell_t;

endpackage

>>> rtl/core/spe_front.sv
// front pipeline: position wrap, rate rom, phase and quadrant split
module spe_front
  import spe_pkg::*;
#(
  parameter int unsigned EMBED_DIM     = 512,
  parameter int unsigned MAX_POSITIONS = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      stall_o,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic [POS_W-1:0]          position_i,
  input  logic [COL_W-1:0]          column_i,
  output logic                      valid_o,
  input  logic                      stall_i,
  output spe_cell_t                 data_o
);

  localparam int unsigned HALF = EMBED_DIM / 2;

  function automatic logic [31:0] rate_calc(input int unsigned pair);
    longint unsigned t;
    longint unsigned f;
    longint unsigned z;
    longint unsigned term;
    longint unsigned s;
    longint unsigned prod;
    int unsigned     n;
    int unsigned     sh;
    t    = (64'(pair) * 64'd2 * LOG2_10000_Q32) / 64'(EMBED_DIM);
    n    = 32'(t >> 32);
    f    = t & 64'hFFFF_FFFF;
    z    = (f * LN2_Q32) >> 32;
    term = 64'h1_0000_0000;
    s    = term;
    term = ((term * z) >> 32) / 64'd1;  s = s - term;
    term = ((term * z) >> 32) / 64'd2;  s = s + term;
    term = ((term * z) >> 32) / 64'd3;  s = s - term;
    term = ((term * z) >> 32) / 64'd4;  s = s + term;
    term = ((term * z) >> 32) / 64'd5;  s = s - term;
    term = ((term * z) >> 32) / 64'd6;  s = s + term;
    term = ((term * z) >> 32) / 64'd7;  s = s - term;
    term = ((term * z) >> 32) / 64'd8;  s = s + term;
    term = ((term * z) >> 32) / 64'd9;  s = s - term;
    term = ((term * z) >> 32) / 64'd10; s = s + term;
    term = ((term * z) >> 32) / 64'd11; s = s - term;
    term = ((term * z) >> 32) / 64'd12; s = s + term;
    term = ((term * z) >> 32) / 64'd13; s = s - term;
    if (n > 20) begin
      return 32'd0;
    end
    prod = s * INV2PI_Q32;
    sh   = 32 + n;
    return 32'((prod + (64'd1 << (sh - 1))) >> sh);
  endfunction

  logic [31:0] rate_rom [ROM_DEPTH];

  for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
    localparam int unsigned PAIR = g % HALF;
    localparam logic [31:0] RATE = rate_calc(PAIR);
    assign rate_rom[g] = RATE;
  end

  logic hold1, hold2, hold3, hold4;
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q;

  logic signed [VALUE_W-1:0] s1_value_q, s2_value_q, s3_value_q;
  logic                      s1_odd_q, s2_odd_q, s3_odd_q;
  logic [POS_W-1:0]          s1_pos_q, s2_pos_q, pos_w;
  logic [31:0]               s1_rate_q, s2_rate_q, s3_phase_q;
  logic [POS_W+31:0]         phase_prod;
  logic [31:0]               quad_sum, resid;
  spe_cell_t                 s4_d, s4_q;

  assign hold4   = s4_v_q && stall_i;
  assign hold3   = s3_v_q && hold4;
  assign hold2   = s2_v_q && hold3;
  assign hold1   = s1_v_q && hold2;
  assign stall_o = hold1;

  if (MAX_POSITIONS < (1 << POS_W)) begin : g_wrap
    localparam int unsigned RECIP =
      ((1 << WRAP_SH) + MAX_POSITIONS - 1) / MAX_POSITIONS;
    localparam logic [POS_W-1:0] MOD = POS_W'(MAX_POSITIONS);
    logic [POS_W+WRAP_SH:0] quo_prod;
    logic [POS_W-1:0]       quo_q;
    logic [2*POS_W-1:0]     quo_mul;
    logic [POS_W-1:0]       rem;

    assign quo_prod = (POS_W + WRAP_SH + 1)'(position_i)
                    * (POS_W + WRAP_SH + 1)'(RECIP);

    always_ff @(posedge clk_i) begin
      if (valid_i && !hold1) begin
        quo_q <= quo_prod[WRAP_SH +: POS_W];
      end
    end

    assign quo_mul = (2 * POS_W)'(quo_q) * (2 * POS_W)'(MOD);
    assign rem     = s1_pos_q - quo_mul[POS_W-1:0];
    assign pos_w   = (rem >= MOD) ? rem - MOD : rem;
  end else begin : g_nowrap
    assign pos_w = s1_pos_q;
  end

  assign phase_prod = (POS_W + 32)'(s2_pos_q) * (POS_W + 32)'(s2_rate_q);

  // nearest quarter turn and residual in [-1/8, 1/8)
  assign quad_sum = s3_phase_q + 32'h2000_0000;
  assign resid    = s3_phase_q - {quad_sum[31:30], 30'd0};

  always_comb begin
    s4_d.value = s3_value_q;
    s4_d.odd   = s3_odd_q;
    s4_d.quad  = quad_sum[31:30];
    s4_d.x     = CORDIC_GAIN_Q30;
    s4_d.y     = '0;
    s4_d.z     = signed'(resid);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      if (!hold1) s1_v_q <= valid_i;
      if (!hold2) s2_v_q <= s1_v_q;
      if (!hold3) s3_v_q <= s2_v_q;
      if (!hold4) s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !hold1) begin
      s1_value_q <= value_i;
      s1_odd_q   <= column_i[0];
      s1_pos_q   <= position_i;
      s1_rate_q  <= rate_rom[column_i[COL_W-1:1]];
    end
    if (s1_v_q && !hold2) begin
      s2_value_q <= s1_value_q;
      s2_odd_q   <= s1_odd_q;
      s2_pos_q   <= pos_w;
      s2_rate_q  <= s1_rate_q;
    end
    if (s2_v_q && !hold3) begin
      s3_value_q <= s2_value_q;
      s3_odd_q   <= s2_odd_q;
      s3_phase_q <= phase_prod[31:0];
    end
    if (s3_v_q && !hold4) begin
      s4_q <= s4_d;
    end
  end

  assign valid_o = s4_v_q;
  assign data_o  = s4_q;

endmodule

>>> rtl/core/spe_cordic_cell.sv
// one cordic rotation cell of the chain
module spe_cordic_cell
  import spe_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      stall_o,
  input  spe_cell_t data_i,
  output logic      valid_o,
  input  logic      stall_i,
  output spe_cell_t data_o
);

  logic                    valid_q;
  spe_cell_t               data_d, data_q;
  logic signed [ANG_W-1:0] x_in, y_in, dx, dy;

  assign stall_o = valid_q && stall_i;

  assign x_in = data_i.x;
  assign y_in = data_i.y;
  assign dx   = y_in >>> IDX;
  assign dy   = x_in >>> IDX;

  always_comb begin
    data_d = data_i;
    if (!data_i.z[ANG_W-1]) begin
      data_d.x = x_in - dx;
      data_d.y = y_in + dy;
      data_d.z = data_i.z - ATAN_TURNS[IDX];
    end else begin
      data_d.x = x_in + dx;
      data_d.y = y_in - dy;
      data_d.z = data_i.z + ATAN_TURNS[IDX];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/core/spe_back.sv
// back pipeline: quadrant fold, rounding to q4.12 and saturating add
module spe_back
  import spe_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      stall_o,
  input  spe_cell_t                 data_i,
  output logic                      valid_o,
  input  logic                      stall_i,
  output logic signed [VALUE_W-1:0] sum_o
);

  logic hold5, hold6, hold_out;
  logic s5_v_q, s6_v_q, out_v_q;

  logic signed [ANG_W-1:0]   sel_v, s5_v_val_q, round_sum;
  logic signed [VALUE_W-1:0] s5_value_q, s6_value_q, sum_d, sum_q;
  logic signed [CODE_W-1:0]  s6_code_q;
  logic signed [VALUE_W:0]   wide_sum;

  assign hold_out = out_v_q && stall_i;
  assign hold6    = s6_v_q && hold_out;
  assign hold5    = s5_v_q && hold6;
  assign stall_o  = hold5;

  always_comb begin
    case (data_i.quad)
      2'd0:    sel_v = data_i.odd ? data_i.x : data_i.y;
      2'd1:    sel_v = data_i.odd ? -data_i.y : data_i.x;
      2'd2:    sel_v = data_i.odd ? -data_i.x : -data_i.y;
      default: sel_v = data_i.odd ? data_i.y : -data_i.x;
    endcase
  end

  assign round_sum = s5_v_val_q + 32'sd131072;

  assign wide_sum = {s6_value_q[VALUE_W-1], s6_value_q}
                  + {s6_code_q[CODE_W-1], s6_code_q};

  always_comb begin
    if (wide_sum[VALUE_W] != wide_sum[VALUE_W-1]) begin
      sum_d = wide_sum[VALUE_W] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      sum_d = wide_sum[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q  <= 1'b0;
      s6_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (!hold5)    s5_v_q  <= valid_i;
      if (!hold6)    s6_v_q  <= s5_v_q;
      if (!hold_out) out_v_q <= s6_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !hold5) begin
      s5_v_val_q <= sel_v;
      s5_value_q <= data_i.value;
    end
    if (s5_v_q && !hold6) begin
      s6_code_q  <= CODE_W'(round_sum >>> 18);
      s6_value_q <= s5_value_q;
    end
    if (s6_v_q && !hold_out) begin
      sum_q <= sum_d;
    end
  end

  assign valid_o = out_v_q;
  assign sum_o   = sum_q;

endmodule

>>> rtl/core/sinusoidal_position_encoding_add_core.sv
// top level of the sinusoidal position code adder
// register stages from input transfer to sum_o valid
// (4 front stages, the CORDIC_STAGES cordic cells, 3 back stages)
// throughput: one item per cycle while the output is not stalled, set by the registered cordic cell chain
// reset clears only the pipeline valid bits; payload registers are not reset
module sinusoidal_position_encoding_add_core
  import spe_pkg::*;
#(
  parameter int unsigned EMBED_DIM     = 512,
  parameter int unsigned MAX_POSITIONS = 1024,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      stall_o,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic [POS_W-1:0]          position_i,
  input  logic [COL_W-1:0]          column_i,
  output logic                      valid_o,
  input  logic                      stall_i,
  output logic signed [VALUE_W-1:0] sum_o
);

  logic      cell_v [CORDIC_STAGES+1];
  logic      cell_s [CORDIC_STAGES+1];
  spe_cell_t cell_d [CORDIC_STAGES+1];

  spe_front #(
    .EMBED_DIM     (EMBED_DIM),
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (valid_i),
    .stall_o    (stall_o),
    .value_i    (value_i),
    .position_i (position_i),
    .column_i   (column_i),
    .valid_o    (cell_v[0]),
    .stall_i    (cell_s[0]),
    .data_o     (cell_d[0])
  );

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    spe_cordic_cell #(
      .IDX (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cell_v[k]),
      .stall_o (cell_s[k]),
      .data_i  (cell_d[k]),
      .valid_o (cell_v[k+1]),
      .stall_i (cell_s[k+1]),
      .data_o  (cell_d[k+1])
    );
  end

  spe_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cell_v[CORDIC_STAGES]),
    .stall_o (cell_s[CORDIC_STAGES]),
    .data_i  (cell_d[CORDIC_STAGES]),
    .valid_o (valid_o),
    .stall_i (stall_i),
    .sum_o   (sum_o)
  );

endmodule

>>> rtl/core/spe_checker.sv
// port checker for the sinusoidal position code adder and its bind
module spe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        stall_o,
  input logic        valid_o,
  input logic        stall_i,
  input logic [15:0] sum_o
);

  // input side backs up only when the output holds a stalled result
  a_stall_needs_full_out: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i)
  ) else $error("input stalled while output register free");

  // a consumed result frees room for a transfer in the same cycle
  a_drain_frees_input: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !stall_i) |-> !stall_o
  ) else $error("input stalled while output transfer completes");

  a_no_result_after_reset: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !valid_o
  ) else $error("result valid right after reset");

  a_stalled_sum_holds: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> (valid_o && $stable(sum_o))
  ) else $error("stalled result changed");

endmodule

bind sinusoidal_position_encoding_add_core spe_checker u_spe_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .stall_o (stall_o),
  .valid_o (valid_o),
  .stall_i (stall_i),
  .sum_o   (sum_o)
);
